// File: src/rled_pkg.sv
// ----------------------------------------------------------------------------
// rled_pkg: shared types and constants of the escape-code run decoder
// Holds the phase codes, status codes, register indexes and the structs
// that pass configuration and results between the decoder modules.
// ----------------------------------------------------------------------------
package rled_pkg;

  localparam int MAX_ESCAPES    = 10;
  localparam int OUT_COUNT_BITS = 24;
  localparam int POS_W          = $clog2(MAX_ESCAPES + 1);
  localparam int BYTE_W         = 8;
  localparam int CNT_W          = 16;
  localparam int STAT_W         = 2;
  localparam int CMP_W          = (OUT_COUNT_BITS > CNT_W) ? OUT_COUNT_BITS : CNT_W;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 64;
  localparam int ESC_CNT_W      = 4;
  localparam int OUT_LEN_W      = 24;

  // Decoder phases.
  localparam logic [2:0] PH_WAIT     = 3'd0;
  localparam logic [2:0] PH_CNT8     = 3'd1;
  localparam logic [2:0] PH_CNT16_LO = 3'd2;
  localparam logic [2:0] PH_CNT16_HI = 3'd3;
  localparam logic [2:0] PH_VALUE    = 3'd4;

  // Escape positions with a count field after them.
  localparam logic [POS_W-1:0] POS_NONE  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_CNT8  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CNT16 = POS_W'(3);

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SHORT    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_HIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_CNT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LEN  = 8'd3;

  typedef struct packed {
    logic [63:0]           esc_low;
    logic [15:0]           esc_high;
    logic [ESC_CNT_W-1:0]  esc_count;
    logic [OUT_LEN_W-1:0]  out_length;
  } cfg_t;

  typedef struct packed {
    logic                emit;
    logic [BYTE_W-1:0]   value;
    logic [CNT_W-1:0]    count;
    logic [STAT_W-1:0]   status;
    logic                done;
  } res_t;

endpackage

// File: src/rled_match.sv
// ----------------------------------------------------------------------------
// rled_match: parallel escape-code compare
// Compares one byte against every escape code in use; the highest matching
// position wins, and zero means the byte is a literal.
// ----------------------------------------------------------------------------
module rled_match (
  input  logic [rled_pkg::BYTE_W-1:0]    byte_in,
  input  logic [63:0]                    esc_low,
  input  logic [15:0]                    esc_high,
  input  logic [rled_pkg::ESC_CNT_W-1:0] esc_count,
  output logic [rled_pkg::POS_W-1:0]     position
);
  import rled_pkg::*;

  logic [79:0]          codes;
  logic [ESC_CNT_W-1:0] in_use;

  assign codes  = {esc_high, esc_low};
  assign in_use = (esc_count > ESC_CNT_W'(MAX_ESCAPES)) ? ESC_CNT_W'(MAX_ESCAPES) : esc_count;

  always_comb begin
    position = POS_NONE;
    for (int i = 0; i < MAX_ESCAPES; i++) begin
      if ((i < int'(in_use)) && (codes[i*BYTE_W +: BYTE_W] == byte_in)) begin
        position = POS_W'(i + 1);
      end
    end
  end

endmodule

// File: src/rled_core.sv
// ----------------------------------------------------------------------------
// rled_core: decoder state and run logic
// Holds the phase, pending count and output tally, and turns one registered
// source byte into at most one run result with limit checking.
// ----------------------------------------------------------------------------
module rled_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [rled_pkg::BYTE_W-1:0] byte_in,
  input  logic                        last_in,
  input  rled_pkg::cfg_t              cfg,
  output rled_pkg::res_t              res
);
  import rled_pkg::*;

  logic [2:0]                phase_r, phase_nxt;
  logic [CNT_W-1:0]          pend_r, pend_nxt;
  logic [OUT_COUNT_BITS-1:0] prod_r, prod_nxt;
  logic                      fin_r, fin_nxt;
  logic                      fail_r, fail_nxt;

  logic [POS_W-1:0]          pos;
  logic [OUT_COUNT_BITS-1:0] limit;
  logic [OUT_COUNT_BITS-1:0] rem;
  logic                      have;
  logic [BYTE_W-1:0]         val;
  logic [CNT_W-1:0]          cnt;
  logic [STAT_W-1:0]         status;
  logic                      done;

  rled_match u_match (
    .byte_in   (byte_in),
    .esc_low   (cfg.esc_low),
    .esc_high  (cfg.esc_high),
    .esc_count (cfg.esc_count),
    .position  (pos)
  );

  assign limit = OUT_COUNT_BITS'(cfg.out_length);
  assign rem   = limit - prod_r;

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    prod_nxt  = prod_r;
    fin_nxt   = fin_r;
    fail_nxt  = fail_r;
    have      = 1'b0;
    val       = '0;
    cnt       = '0;
    status    = STAT_OK;
    done      = 1'b0;

    if (!fin_r) begin
      if (prod_r >= limit) begin
        // Limit already met: finish without a result.
        fin_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_CNT8: begin
            pend_nxt  = CNT_W'(byte_in);
            phase_nxt = PH_VALUE;
          end
          PH_CNT16_LO: begin
            pend_nxt  = CNT_W'(byte_in);
            phase_nxt = PH_CNT16_HI;
          end
          PH_CNT16_HI: begin
            pend_nxt  = {byte_in, pend_r[7:0]};
            phase_nxt = PH_VALUE;
          end
          PH_VALUE: begin
            val       = byte_in;
            cnt       = pend_r;
            have      = 1'b1;
            pend_nxt  = '0;
            phase_nxt = PH_WAIT;
          end
          default: begin
            phase_nxt = PH_WAIT;
            if (pos == POS_NONE) begin
              val  = byte_in;
              cnt  = CNT_W'(1);
              have = 1'b1;
            end else if (pos == POS_CNT8) begin
              phase_nxt = PH_CNT8;
            end else if (pos == POS_CNT16) begin
              phase_nxt = PH_CNT16_LO;
            end else begin
              pend_nxt  = CNT_W'(pos - POS_W'(1));
              phase_nxt = PH_VALUE;
            end
          end
        endcase

        if (have && (cnt == '0)) begin
          have = 1'b0;
        end

        if (have) begin
          if (CMP_W'(cnt) > CMP_W'(rem)) begin
            // The run passes the limit; the clipped count fits in CNT_W.
            cnt      = CNT_W'(rem);
            status   = STAT_OVERFLOW;
            done     = 1'b1;
            fail_nxt = 1'b1;
            fin_nxt  = 1'b1;
          end
          prod_nxt = prod_r + OUT_COUNT_BITS'(cnt);
          if (prod_nxt >= limit) begin
            done    = 1'b1;
            fin_nxt = 1'b1;
          end
        end

        if (!fin_nxt && last_in) begin
          status   = STAT_SHORT;
          done     = 1'b1;
          fail_nxt = 1'b1;
          fin_nxt  = 1'b1;
        end
      end
    end

    res.emit   = have || done;
    res.value  = have ? val : '0;
    res.count  = have ? cnt : '0;
    res.status = status;
    res.done   = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      pend_r  <= '0;
      prod_r  <= '0;
      fin_r   <= 1'b0;
      fail_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      prod_r  <= prod_nxt;
      fin_r   <= fin_nxt;
      fail_r  <= fail_nxt;
    end
  end

endmodule

// File: src/rle_escape_byte_run_decoder.sv
// ----------------------------------------------------------------------------
// rle_escape_byte_run_decoder: escape-code run-length byte decoder
// Decodes a compressed byte stream into (value, count) runs, clipped and
// checked against a programmable output length.
//
//   channel | direction | payload
//   --------+-----------+---------------------------------------------------
//   in_     | sink      | tdata = in_byte, tlast = last_byte
//   out_    | source    | tdata = run_value, run_count; tuser = status;
//           |           | tlast = done_res
//   cfg_    | sink      | cfg_index = register, cfg_data = value
//
// One byte is accepted per cycle; it is decoded from the input register and
// its run is loaded into the output register, from which the result is
// presented. A byte with a result waits in the input register while the
// output register is full and stalled, and input stops; a byte without a
// result retires at once. Reset is synchronous and clears the decoder
// state, the registers (out_length to 1) and both valid flags.
// ----------------------------------------------------------------------------
module rle_escape_byte_run_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  // Source bytes.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] in_byte
  input  logic                            in_tlast,   // last_byte
  // Decoded runs.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // [7:0] run_value, [23:8] run_count
  output logic [1:0]                      out_tuser,  // [1:0] status
  output logic                            out_tlast,  // done_res
  // Register writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rled_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rled_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rled_pkg::*;

  cfg_t              cfg_r;
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  res_t              res;
  res_t              out_r;
  logic              out_valid_r;
  logic              out_free;
  logic              s1_adv;

  assign cfg_ready = rst_n;
  assign out_free  = !out_valid_r || out_tready;
  // A byte without a result retires even while the output register is full.
  assign s1_adv    = s1_valid_r && (!res.emit || out_free);
  assign in_tready = rst_n && (!s1_valid_r || s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.esc_low    <= '0;
      cfg_r.esc_high   <= '0;
      cfg_r.esc_count  <= '0;
      cfg_r.out_length <= OUT_LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ESC_LOW:  cfg_r.esc_low    <= cfg_data[63:0];
        CFG_ESC_HIGH: cfg_r.esc_high   <= cfg_data[15:0];
        CFG_ESC_CNT:  cfg_r.esc_count  <= cfg_data[ESC_CNT_W-1:0];
        CFG_OUT_LEN:  cfg_r.out_length <= cfg_data[OUT_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  rled_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .byte_in (s1_byte_r),
    .last_in (s1_last_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.count, out_r.value};
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.done;

endmodule

// File: src/rled_checker.sv
// ----------------------------------------------------------------------------
// rled_checker: port-level checks for the run decoder
// Watches the result channel for ordering and encoding rules of the runs.
// ----------------------------------------------------------------------------
module rled_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import rled_pkg::*;

  logic seen_done_r;

  // Set once the final result has been taken; cleared only by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_done_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tlast) begin
      seen_done_r <= 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_nothing_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(seen_done_r && out_tvalid))
    else $error("result after decoding finished");

  a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_OVERFLOW || out_tuser == STAT_SHORT) |-> out_tlast)
    else $error("error status without done");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[23:8] != 16'd0)
    else $error("empty run emitted mid-stream");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined status code");

endmodule

bind rle_escape_byte_run_decoder rled_checker u_rled_checker (.*);

// File: bench/rle_escape_byte_run_decoder_tb.sv
// ----------------------------------------------------------------------------
// rle_escape_byte_run_decoder_tb: self-checking bench for the run decoder
// Streams escape sequences, literals and noise into the decoder under four
// idling patterns. A scoreboard predicts every (value, count) run with its
// status and compares each result in order. The run ends with exactly one of
// the ways decoding can finish, followed by bytes that must be ignored.
// ----------------------------------------------------------------------------
module rle_escape_byte_run_decoder_tb;
  import rled_pkg::*;

  localparam int RUN_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 6;
  // Indexes that address no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

  typedef enum int {
    END_LIMIT, END_OVERFLOW, END_SHORT, END_SILENT, END_LAST_AT_LIMIT
  } ending_e;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] status;
    logic              done;
  } run_t;

  class run_scoreboard;
    logic [63:0]          esc_low;
    logic [15:0]          esc_high;
    logic [ESC_CNT_W-1:0] esc_count;
    logic [OUT_LEN_W-1:0] out_len;
    logic [2:0]           phase;
    logic [CNT_W-1:0]     pend_count;
    logic [OUT_LEN_W-1:0] produced;
    bit                   finished;
    bit                   failed;
    run_t                 expected_runs[$];
    int                   errors;

    function new();
      esc_low = '0;
      esc_high = '0;
      esc_count = '0;
      out_len = 24'd1;
      phase = PH_WAIT;
      pend_count = '0;
      produced = '0;
      finished = 0;
      failed = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ESC_LOW:  esc_low = data;
        CFG_ESC_HIGH: esc_high = data[15:0];
        CFG_ESC_CNT:  esc_count = data[ESC_CNT_W-1:0];
        CFG_OUT_LEN:  out_len = data[OUT_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int active_codes();
      return (int'(esc_count) > MAX_ESCAPES) ? MAX_ESCAPES : int'(esc_count);
    endfunction

    function logic [7:0] code_at(int pos);
      return (pos <= 8) ? esc_low[8*(pos-1) +: 8] : esc_high[8*(pos-9) +: 8];
    endfunction

    // The highest matching position wins when codes repeat.
    function int escape_position(logic [7:0] b);
      int p;
      p = int'(POS_NONE);
      for (int i = 1; i <= active_codes(); i++)
        if (code_at(i) == b) p = i;
      return p;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int p;
      bit have;
      bit done;
      logic [7:0] val;
      logic [OUT_LEN_W-1:0] cnt;
      logic [STAT_W-1:0] st;
      run_t r;
      have = 0;
      done = 0;
      val = '0;
      cnt = '0;
      st = STAT_OK;
      if (finished) return;
      if (produced >= out_len) begin
        finished = 1;
        return;
      end
      case (phase)
        PH_WAIT: begin
          p = escape_position(b);
          if (p == int'(POS_NONE)) begin
            val = b;
            cnt = OUT_LEN_W'(1);
            have = 1;
          end else if (p == int'(POS_CNT8)) begin
            phase = PH_CNT8;
          end else if (p == int'(POS_CNT16)) begin
            phase = PH_CNT16_LO;
          end else begin
            pend_count = CNT_W'(p - 1);
            phase = PH_VALUE;
          end
        end
        PH_CNT8: begin
          pend_count = CNT_W'(b);
          phase = PH_VALUE;
        end
        PH_CNT16_LO: begin
          pend_count = CNT_W'(b);
          phase = PH_CNT16_HI;
        end
        PH_CNT16_HI: begin
          pend_count[15:8] = b;
          phase = PH_VALUE;
        end
        default: begin
          val = b;
          cnt = OUT_LEN_W'(pend_count);
          have = 1;
          pend_count = '0;
          phase = PH_WAIT;
        end
      endcase
      if (have && cnt == '0) have = 0;
      if (have) begin
        if (cnt > out_len - produced) begin
          cnt = out_len - produced;
          st = STAT_OVERFLOW;
          done = 1;
          failed = 1;
          finished = 1;
        end
        produced = produced + cnt;
        if (produced >= out_len) begin
          done = 1;
          finished = 1;
        end
      end
      if (!finished && last) begin
        st = STAT_SHORT;
        done = 1;
        failed = 1;
        finished = 1;
      end
      if (have || done) begin
        r.value = have ? val : '0;
        r.count = have ? cnt[CNT_W-1:0] : '0;
        r.status = st;
        r.done = done;
        expected_runs.push_back(r);
      end
    endfunction

    function void check_run(run_t got);
      run_t want;
      if (expected_runs.size() == 0) begin
        errors++;
        $display("%0t: unexpected run value=%0h count=%0d status=%0d done=%0d",
                 $time, got.value, got.count, got.status, got.done);
        return;
      end
      want = expected_runs.pop_front();
      if (got.value !== want.value) begin
        errors++;
        $display("%0t: run value expected %0h got %0h", $time, want.value, got.value);
      end
      if (got.count !== want.count) begin
        errors++;
        $display("%0t: run count expected %0d got %0d", $time, want.count, got.count);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: run status expected %0d got %0d", $time, want.status, got.status);
      end
      if (got.done !== want.done) begin
        errors++;
        $display("%0t: run done expected %0d got %0d", $time, want.done, got.done);
      end
    endfunction

    function int pending();
      return expected_runs.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [23:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  run_scoreboard sb;
  int send_idle = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int cycle_count = 0;

  // Directed codes: position 1 is 00, position 3 is FF, position 2 is 91,
  // positions 4 to 10 are 93 to 99.
  localparam logic [63:0] DIR_ESC_LOW  = 64'h9796_9594_93FF_9100;
  localparam logic [15:0] DIR_ESC_HIGH = 16'h9998;

  logic [7:0] directed_bytes [] = '{
    8'h80,                         // literal
    8'h00, 8'hFF, 8'h55,           // byte count at its maximum
    8'h00, 8'h00, 8'hAA,           // zero-length run
    8'hFF, 8'h34, 8'h12, 8'h7E,    // 16-bit count, little endian
    8'hFF, 8'hFF, 8'hFF, 8'h00,    // 16-bit count at its maximum
    8'h91, 8'h11,                  // position 2, one copy
    8'h99, 8'h22,                  // position 10, nine copies
    8'h93, 8'h44                   // position 4, three copies
  };

  rle_escape_byte_run_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_run({out_tdata[7:0], out_tdata[23:8], out_tuser, out_tlast});
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  // Holds the sender off until every predicted run has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic quiesce();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_literal(logic last);
    logic [7:0] b;
    int tries;
    tries = 0;
    do begin
      b = 8'($urandom_range(255));
      tries++;
    end while (sb.escape_position(b) != int'(POS_NONE) && tries < 64);
    send_byte(b, last);
  endtask

  task automatic send_random_sequence();
    int pick;
    int p;
    logic [7:0] code;
    pick = $urandom_range(99);
    if (pick < 10 || (pick >= 45 && sb.active_codes() == 0)) begin
      send_byte(8'($urandom_range(255)), 1'b0);
    end else if (pick < 45) begin
      send_literal(1'b0);
    end else begin
      code = sb.code_at($urandom_range(1, sb.active_codes()));
      p = sb.escape_position(code);
      send_byte(code, 1'b0);
      if (p == int'(POS_CNT8)) begin
        send_byte(($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255)), 1'b0);
      end else if (p == int'(POS_CNT16)) begin
        if ($urandom_range(15) == 0) begin
          send_byte(8'd0, 1'b0);
          send_byte(8'd0, 1'b0);
        end else begin
          send_byte(8'($urandom_range(255)), 1'b0);
          // Mostly short runs keep the total far below the length limit.
          send_byte(($urandom_range(15) == 0) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(3)), 1'b0);
        end
      end
      send_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic random_phase(int sender_pct, int receiver_pct, logic [63:0] low,
                              logic [15:0] high, logic [3:0] n_codes,
                              bit full_length, int n_items);
    int unsigned target;
    int start;
    quiesce();
    target = 32'(sb.produced) + 32'h40_0000 + $urandom_range(32'h3F_FFFF);
    if (full_length || target > 32'hFF_FFFF) target = 32'hFF_FFFF;
    write_reg(CFG_ESC_LOW, low);
    write_reg(CFG_ESC_HIGH, 64'(high));
    write_reg(CFG_ESC_CNT, 64'(n_codes));
    write_reg(CFG_OUT_LEN, 64'(target));
    send_idle = sender_pct;
    stall_pct = receiver_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      if ($urandom_range(99) == 0) drain();
      send_random_sequence();
    end
  endtask

  initial begin
    ending_e ending;
    int unsigned base;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the full code set and the largest length.
    write_reg(CFG_ESC_LOW, DIR_ESC_LOW);
    write_reg(CFG_ESC_HIGH, 64'(DIR_ESC_HIGH));
    write_reg(CFG_ESC_CNT, 64'd10);
    write_reg(CFG_OUT_LEN, 64'hFF_FFFF);
    write_reg(CFG_UNUSED_LO, '1);
    write_reg(CFG_UNUSED_HI, '1);
    foreach (directed_bytes[i]) send_byte(directed_bytes[i], 1'b0);
    // Position 9 now repeats the position 1 code and must win; the count
    // above the maximum saturates.
    quiesce();
    write_reg(CFG_ESC_HIGH, 64'h9900);
    write_reg(CFG_ESC_CNT, 64'd15);
    send_byte(8'h00, 1'b0);
    send_byte(8'h66, 1'b0);
    // With no codes in use every byte is a literal.
    quiesce();
    write_reg(CFG_ESC_CNT, 64'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);

    random_phase(0, 0, {$urandom, $urandom}, 16'($urandom), 4'd10, 1, 300);
    random_phase(75, 0, {$urandom, $urandom}, 16'($urandom), 4'd15, 0, 300);
    random_phase(0, 75, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 4'($urandom_range(3, 9)), 1,
                 300);
    random_phase(17, 17, {$urandom, $urandom}, 16'($urandom), 4'($urandom_range(1, 10)),
                 0, 300);

    // Decoding can finish only once per reset, so one ending is picked.
    quiesce();
    write_reg(CFG_ESC_LOW, DIR_ESC_LOW);
    write_reg(CFG_ESC_HIGH, 64'(DIR_ESC_HIGH));
    write_reg(CFG_ESC_CNT, 64'd10);
    base = 32'(sb.produced);
    ending = ending_e'($urandom_range(4));
    case (ending)
      END_LIMIT: begin
        write_reg(CFG_OUT_LEN, 64'(base + $urandom_range(1, 40)));
        while (!sb.finished) send_literal(1'b0);
      end
      END_OVERFLOW: begin
        write_reg(CFG_OUT_LEN, 64'(base + $urandom_range(1, 200)));
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      END_SHORT: begin
        if ($urandom_range(1)) begin
          send_literal(1'b1);
        end else begin
          send_byte(8'h00, 1'b0);
          send_byte(8'($urandom_range(255)), 1'b1);
        end
      end
      END_SILENT: begin
        write_reg(CFG_OUT_LEN, $urandom_range(1) ? 64'd0 : 64'(base));
      end
      default: begin
        write_reg(CFG_OUT_LEN, 64'(base + 1));
        send_literal(1'b1);
      end
    endcase
    // Everything after the finish must be dropped.
    repeat (16) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/rled_pkg.sv
src/rled_match.sv
src/rled_core.sv
src/rle_escape_byte_run_decoder.sv
src/rled_checker.sv
bench/rle_escape_byte_run_decoder_tb.sv
